### sv/bfte_pkg.sv
// ---------------------------------------------------------------------------
// Boys function evaluator package
// Shared types, constants and defaults for the table evaluator and its units.
// ---------------------------------------------------------------------------
package bfte_pkg;

  // Default table geometry
  localparam int ORDERS_DEF    = 32;
  localparam int INTERVALS_DEF = 256;
  localparam int TERMS_DEF     = 8;

  // Field widths
  localparam int CMD_W   = 2;
  localparam int ORDER_W = 6;
  localparam int ARG_W   = 48;
  localparam int ISEL_W  = 8;
  localparam int TSEL_W  = 4;
  localparam int WORD_W  = 64;
  localparam int RES_W   = 63;
  localparam int CFG_IDX_W = 2;

  // Saturation limits of the signed Q3.60 word
  localparam logic [WORD_W-1:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [WORD_W-1:0] SMIN = 64'h8000_0000_0000_0000;

  // Register reset values (Q16.32)
  localparam logic [ARG_W-1:0] X_LIMIT_RST = 48'd171798691840;
  localparam logic [ARG_W-1:0] INV_RST     = 48'd27487790694;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_X_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_WIDTH = 2'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_EVAL    = 2'd0,
    CMD_LD_COEF = 2'd1,
    CMD_LD_PF   = 2'd2,
    CMD_LD_MID  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ORDER    = 2'd1,
    ST_INTERVAL = 2'd2,
    ST_TERM     = 2'd3
  } status_t;

  typedef enum logic {
    DM_DIV  = 1'b0,
    DM_SQRT = 1'b1
  } div_mode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_IDX_WAIT,
    S_TAY_RD,
    S_TAY_INIT,
    S_TAY_MUL,
    S_TAY_WAIT,
    S_PF_CHK,
    S_SQRT_WAIT,
    S_DIV_WAIT,
    S_DONE
  } state_t;

  // Status of a multi-cycle arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

### sv/bfte_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module bfte_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### sv/bfte_mul.sv
// ---------------------------------------------------------------------------
// Shared multiplier
// 64 x 64 unsigned product built from four 32 x 32 partial products.
// ---------------------------------------------------------------------------
module bfte_mul (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [63:0]         a,
  input  logic [63:0]         b,
  output logic [127:0]        prod,
  output bfte_pkg::unit_stat_t stat
);

  logic [63:0]  a_r, b_r;
  logic [127:0] acc_r;
  logic [1:0]   cnt_r;
  logic         run_r, done_r;
  logic [31:0]  ah, bh;
  logic [63:0]  pp;
  logic [127:0] pp_sh;

  // Select the halves for this step and align the partial product.
  always_comb begin
    ah = cnt_r[1] ? a_r[63:32] : a_r[31:0];
    bh = cnt_r[0] ? b_r[63:32] : b_r[31:0];
    pp = ah * bh;
    unique case (cnt_r)
      2'b00:        pp_sh = {64'b0, pp};
      2'b01, 2'b10: pp_sh = {32'b0, pp, 32'b0};
      default:      pp_sh = {pp, 64'b0};
    endcase
  end

  // Step control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      done_r <= run_r && (cnt_r == 2'd3);
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= 2'd0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  // Operands and accumulator.
  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (run_r) begin
      acc_r <= acc_r + pp_sh;
    end
  end

  assign prod      = acc_r;
  assign stat.busy = run_r;
  assign stat.done = done_r;

endmodule

### sv/bfte_div.sv
// ---------------------------------------------------------------------------
// Shared divide and square root unit
// Restoring division one quotient bit a cycle, or digit-by-digit square root
// one root bit a cycle, on one compare-subtract datapath.
// ---------------------------------------------------------------------------
module bfte_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  bfte_pkg::div_mode_t  mode,
  input  logic [63:0]          num_hi,
  input  logic [63:0]          num_lo,
  input  logic [63:0]          den,
  output logic [63:0]          res,
  output bfte_pkg::unit_stat_t stat
);

  localparam logic [6:0] DIV_LAST  = 7'd63;
  localparam logic [6:0] SQRT_LAST = 7'd39;

  bfte_pkg::div_mode_t mode_r;
  logic [65:0] rem_r, rem_sh, trial, rem_nxt;
  logic [66:0] diff;
  logic [63:0] q_r, q_nxt, den_r, res_r;
  logic [79:0] sh_r, sh_nxt;
  logic [6:0]  cnt_r;
  logic        run_r, done_r, ge, last;

  // One compare-subtract step.
  always_comb begin
    if (mode_r == bfte_pkg::DM_SQRT) begin
      rem_sh = {rem_r[63:0], sh_r[79:78]};
      trial  = {q_r, 2'b01};
      sh_nxt = {sh_r[77:0], 2'b00};
      last   = (cnt_r == SQRT_LAST);
    end else begin
      rem_sh = {rem_r[64:0], sh_r[79]};
      trial  = {2'b00, den_r};
      sh_nxt = {sh_r[78:0], 1'b0};
      last   = (cnt_r == DIV_LAST);
    end
    diff    = {1'b0, rem_sh} - {1'b0, trial};
    ge      = !diff[66];
    rem_nxt = ge ? diff[65:0] : rem_sh;
    q_nxt   = {q_r[62:0], ge};
  end

  // Control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 7'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= 7'd0;
        if (mode == bfte_pkg::DM_DIV && (den == 64'd0 || num_hi >= den)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          run_r <= 1'b1;
        end
      end else if (run_r) begin
        cnt_r <= cnt_r + 7'd1;
        if (last) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (start) begin
      mode_r <= mode;
      den_r  <= den;
      q_r    <= '0;
      res_r  <= bfte_pkg::SMAX;
      if (mode == bfte_pkg::DM_SQRT) begin
        rem_r <= '0;
        sh_r  <= {num_lo[47:0], 32'b0};
      end else begin
        rem_r <= {2'b00, num_hi};
        sh_r  <= {num_lo, 16'b0};
      end
    end else if (run_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
      sh_r  <= sh_nxt;
      if (last) begin
        if (mode_r == bfte_pkg::DM_DIV && q_nxt[63]) begin
          res_r <= bfte_pkg::SMAX;
        end else begin
          res_r <= q_nxt;
        end
      end
    end
  end

  assign res       = res_r;
  assign stat.busy = run_r;
  assign stat.done = done_r;

endmodule

### sv/boys_function_table_evaluator.sv
// ---------------------------------------------------------------------------
// Boys function table evaluator
// Evaluates F_n(x) from host-loaded Taylor, midpoint and prefactor tables.
// ---------------------------------------------------------------------------
// One request is handled at a time; in_ready is high only while the block is
// idle. A Taylor evaluation runs a 4-step multiply for the interval index,
// then one 4-step multiply and a saturating add per Horner term on the shared
// 32x32 multiplier. A large-x evaluation runs a 40-step square root and n+1
// divisions of up to 64 steps each on the shared bit-serial divider. A finished
// result waits in the output register while the next request is taken.
module boys_function_table_evaluator #(
  parameter int ORDERS    = bfte_pkg::ORDERS_DEF,
  parameter int INTERVALS = bfte_pkg::INTERVALS_DEF,
  parameter int TERMS     = bfte_pkg::TERMS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [5:0]  in_order,
  input  logic [47:0] in_argument,
  input  logic [7:0]  in_interval_select,
  input  logic [3:0]  in_term_select,
  input  logic signed [63:0] in_load_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [62:0] out_result_value,
  output logic [1:0]  out_status,
  output logic        out_used_large_x
);

  localparam int OW = (ORDERS > 1) ? $clog2(ORDERS) : 1;
  localparam int IW = (INTERVALS > 1) ? $clog2(INTERVALS) : 1;
  localparam int TW = (TERMS > 1) ? $clog2(TERMS) : 1;
  localparam int CDEPTH = ORDERS * INTERVALS * TERMS;
  localparam int CW = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
  localparam logic [TW-1:0] K_TOP = TW'(TERMS - 1);

  // Signed Q3.60 saturating add.
  function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    r = a + b;
    if (((a ^ b) & bfte_pkg::SMIN) == 64'd0 && ((r ^ a) & bfte_pkg::SMIN) != 64'd0) begin
      return a[63] ? bfte_pkg::SMIN : bfte_pkg::SMAX;
    end
    return r;
  endfunction

  // Scale a magnitude product back to Q3.60, apply sign and saturate.
  function automatic logic [63:0] scale_q(input logic [127:0] p, input logic neg);
    logic [63:0] l2;
    logic        hi_nz;
    l2    = p[95:32];
    hi_nz = |p[127:96];
    if (neg) begin
      if (hi_nz || l2 > bfte_pkg::SMIN) begin
        return bfte_pkg::SMIN;
      end
      return 64'd0 - l2;
    end
    if (hi_nz || l2 > bfte_pkg::SMAX) begin
      return bfte_pkg::SMAX;
    end
    return l2;
  endfunction

  bfte_pkg::state_t state_r, state_nxt;

  // Configuration and request registers
  logic [47:0] x_limit_r, inv_r;
  bfte_pkg::cmd_t cmd_r;
  logic [5:0]  n_r;
  logic [47:0] x_r;
  logic [7:0]  isel_r;
  logic [3:0]  tsel_r;
  logic [63:0] val_r;

  // Working registers
  logic [IW-1:0] j_r, j_nxt;
  logic [TW-1:0] k_r, k_nxt;
  logic [5:0]    cnt_r, cnt_nxt;
  logic [63:0]   acc_r, acc_nxt;
  logic [47:0]   dmag_r, dmag_nxt;
  logic          dneg_r, dneg_nxt;
  logic [63:0]   pres_r, pres_nxt;
  bfte_pkg::status_t pstat_r, pstat_nxt;
  logic          plarge_r, plarge_nxt;

  // Output registers
  logic          out_valid_r;
  logic [62:0]   out_res_r;
  bfte_pkg::status_t out_stat_r;
  logic          out_large_r;

  // Unit interfaces
  logic          mul_start;
  logic [63:0]   mul_a, mul_b;
  logic [127:0]  mul_prod;
  bfte_pkg::unit_stat_t mul_st;
  logic          div_start;
  bfte_pkg::div_mode_t div_mode;
  logic [63:0]   div_hi, div_lo, div_den, div_res;
  bfte_pkg::unit_stat_t div_st;

  // Table ports
  logic          coef_we, mid_we, pf_we;
  logic [CW-1:0] coef_waddr, coef_raddr;
  logic [63:0]   coef_rdata, pf_rdata;
  logic [47:0]   mid_rdata;

  logic          order_bad, isel_bad, tsel_bad, load_ok;
  logic [63:0]   prodq, sum;
  logic          taking;

  // Coefficient table addresses: ((n * INTERVALS + j) * TERMS + k).
  assign coef_waddr = CW'((32'(n_r) * 32'(INTERVALS) + 32'(isel_r)) * 32'(TERMS)
                          + 32'(tsel_r));
  assign coef_raddr = CW'((32'(n_r) * 32'(INTERVALS) + 32'(j_r)) * 32'(TERMS)
                          + 32'(k_r));

  bfte_ram #(.WIDTH(64), .DEPTH(CDEPTH), .AW(CW)) u_coef_ram (
    .clk(clk), .we(coef_we), .waddr(coef_waddr), .wdata(val_r),
    .raddr(coef_raddr), .rdata(coef_rdata)
  );

  bfte_ram #(.WIDTH(48), .DEPTH(INTERVALS), .AW(IW)) u_mid_ram (
    .clk(clk), .we(mid_we), .waddr(isel_r[IW-1:0]), .wdata(val_r[47:0]),
    .raddr(j_r), .rdata(mid_rdata)
  );

  bfte_ram #(.WIDTH(64), .DEPTH(ORDERS), .AW(OW)) u_pf_ram (
    .clk(clk), .we(pf_we), .waddr(n_r[OW-1:0]), .wdata(val_r),
    .raddr(n_r[OW-1:0]), .rdata(pf_rdata)
  );

  bfte_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
    .prod(mul_prod), .stat(mul_st)
  );

  bfte_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .mode(div_mode),
    .num_hi(div_hi), .num_lo(div_lo), .den(div_den), .res(div_res), .stat(div_st)
  );

  // Range checks on the held request.
  assign order_bad = ({1'b0, n_r} >= 7'(ORDERS));
  assign isel_bad  = ({1'b0, isel_r} >= 9'(INTERVALS));
  assign tsel_bad  = ({1'b0, tsel_r} >= 5'(TERMS));

  // Horner step: product of the running sum and the offset, plus the next term.
  assign prodq = scale_q(mul_prod, acc_r[63] != dneg_r);
  assign sum   = add_sat(coef_rdata, prodq);

  assign in_ready = (state_r == bfte_pkg::S_IDLE);
  assign taking   = !out_valid_r || out_ready;

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bfte_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencer next state and unit control.
  always_comb begin
    state_nxt  = state_r;
    j_nxt      = j_r;
    k_nxt      = k_r;
    cnt_nxt    = cnt_r;
    acc_nxt    = acc_r;
    dmag_nxt   = dmag_r;
    dneg_nxt   = dneg_r;
    pres_nxt   = pres_r;
    pstat_nxt  = pstat_r;
    plarge_nxt = plarge_r;
    mul_start  = 1'b0;
    mul_a      = {16'b0, x_r};
    mul_b      = {16'b0, inv_r};
    div_start  = 1'b0;
    div_mode   = bfte_pkg::DM_DIV;
    div_hi     = {32'b0, acc_r[63:32]};
    div_lo     = {acc_r[31:0], 32'b0};
    div_den    = {16'b0, x_r};
    coef_we    = 1'b0;
    mid_we     = 1'b0;
    pf_we      = 1'b0;
    load_ok    = 1'b0;
    unique case (state_r)
      bfte_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = bfte_pkg::S_DECODE;
        end
      end
      bfte_pkg::S_DECODE: begin
        pres_nxt   = '0;
        pstat_nxt  = bfte_pkg::ST_OK;
        plarge_nxt = 1'b0;
        state_nxt  = bfte_pkg::S_DONE;
        unique case (cmd_r)
          bfte_pkg::CMD_LD_COEF: begin
            priority if (order_bad) pstat_nxt = bfte_pkg::ST_ORDER;
            else if (isel_bad)      pstat_nxt = bfte_pkg::ST_INTERVAL;
            else if (tsel_bad)      pstat_nxt = bfte_pkg::ST_TERM;
            else                    load_ok = 1'b1;
            coef_we = load_ok;
          end
          bfte_pkg::CMD_LD_PF: begin
            if (order_bad) begin
              pstat_nxt = bfte_pkg::ST_ORDER;
            end else begin
              pf_we = 1'b1;
            end
          end
          bfte_pkg::CMD_LD_MID: begin
            if (isel_bad) begin
              pstat_nxt = bfte_pkg::ST_INTERVAL;
            end else begin
              mid_we = 1'b1;
            end
          end
          default: begin
            priority if (order_bad) begin
              pstat_nxt = bfte_pkg::ST_ORDER;
            end else if (x_r >= x_limit_r) begin
              plarge_nxt = 1'b1;
              state_nxt  = bfte_pkg::S_PF_CHK;
            end else begin
              mul_start = 1'b1;
              state_nxt = bfte_pkg::S_IDX_WAIT;
            end
          end
        endcase
      end
      bfte_pkg::S_IDX_WAIT: begin
        if (mul_st.done) begin
          if (mul_prod[127:64] >= 64'(INTERVALS)) begin
            pstat_nxt = bfte_pkg::ST_INTERVAL;
            state_nxt = bfte_pkg::S_DONE;
          end else begin
            j_nxt     = mul_prod[64 +: IW];
            k_nxt     = K_TOP;
            state_nxt = bfte_pkg::S_TAY_RD;
          end
        end
      end
      bfte_pkg::S_TAY_RD: begin
        state_nxt = bfte_pkg::S_TAY_INIT;
      end
      bfte_pkg::S_TAY_INIT: begin
        dneg_nxt = x_r < mid_rdata;
        dmag_nxt = dneg_nxt ? (mid_rdata - x_r) : (x_r - mid_rdata);
        acc_nxt  = coef_rdata;
        if (k_r == '0) begin
          pres_nxt  = coef_rdata[63] ? 64'd0 : coef_rdata;
          state_nxt = bfte_pkg::S_DONE;
        end else begin
          k_nxt     = k_r - TW'(1);
          state_nxt = bfte_pkg::S_TAY_MUL;
        end
      end
      bfte_pkg::S_TAY_MUL: begin
        mul_start = 1'b1;
        mul_a     = acc_r[63] ? (64'd0 - acc_r) : acc_r;
        mul_b     = {16'b0, dmag_r};
        state_nxt = bfte_pkg::S_TAY_WAIT;
      end
      bfte_pkg::S_TAY_WAIT: begin
        if (mul_st.done) begin
          acc_nxt = sum;
          if (k_r == '0) begin
            pres_nxt  = sum[63] ? 64'd0 : sum;
            state_nxt = bfte_pkg::S_DONE;
          end else begin
            k_nxt     = k_r - TW'(1);
            state_nxt = bfte_pkg::S_TAY_MUL;
          end
        end
      end
      bfte_pkg::S_PF_CHK: begin
        acc_nxt = pf_rdata;
        if (pf_rdata[63] || pf_rdata == 64'd0) begin
          state_nxt = bfte_pkg::S_DONE;
        end else begin
          div_start = 1'b1;
          div_mode  = bfte_pkg::DM_SQRT;
          div_lo    = {16'b0, x_r};
          state_nxt = bfte_pkg::S_SQRT_WAIT;
        end
      end
      bfte_pkg::S_SQRT_WAIT: begin
        if (div_st.done) begin
          div_start = 1'b1;
          div_den   = div_res;
          cnt_nxt   = '0;
          state_nxt = bfte_pkg::S_DIV_WAIT;
        end
      end
      bfte_pkg::S_DIV_WAIT: begin
        if (div_st.done) begin
          acc_nxt = div_res;
          if (cnt_r == n_r) begin
            pres_nxt  = div_res;
            state_nxt = bfte_pkg::S_DONE;
          end else begin
            cnt_nxt   = cnt_r + 6'd1;
            div_start = 1'b1;
            div_hi    = {32'b0, div_res[63:32]};
            div_lo    = {div_res[31:0], 32'b0};
            state_nxt = bfte_pkg::S_DIV_WAIT;
          end
        end
      end
      bfte_pkg::S_DONE: begin
        if (taking) begin
          state_nxt = bfte_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bfte_pkg::S_IDLE;
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_limit_r <= bfte_pkg::X_LIMIT_RST;
      inv_r     <= bfte_pkg::INV_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bfte_pkg::REG_X_LIMIT:   x_limit_r <= cfg_wdata;
        bfte_pkg::REG_INV_WIDTH: inv_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Request capture and working registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r  <= bfte_pkg::cmd_t'(in_command);
      n_r    <= in_order;
      x_r    <= in_argument;
      isel_r <= in_interval_select;
      tsel_r <= in_term_select;
      val_r  <= in_load_value;
    end
    j_r      <= j_nxt;
    k_r      <= k_nxt;
    cnt_r    <= cnt_nxt;
    acc_r    <= acc_nxt;
    dmag_r   <= dmag_nxt;
    dneg_r   <= dneg_nxt;
    pres_r   <= pres_nxt;
    pstat_r  <= pstat_nxt;
    plarge_r <= plarge_nxt;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == bfte_pkg::S_DONE && taking) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == bfte_pkg::S_DONE && taking) begin
      out_res_r   <= pres_r[62:0];
      out_stat_r  <= pstat_r;
      out_large_r <= plarge_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_res_r;
  assign out_status       = out_stat_r;
  assign out_used_large_x = out_large_r;

  // A result from the large-x formula never carries an error.
  a_large_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_large_r) |-> (out_stat_r == bfte_pkg::ST_OK))
    else $error("large-x result with error status");

  // An error result carries a zero value.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stat_r != bfte_pkg::ST_OK) |-> (out_res_r == 63'd0))
    else $error("error result with non-zero value");

  // No arithmetic unit is busy while the block waits for a request.
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bfte_pkg::S_IDLE) |-> (!mul_st.busy && !div_st.busy))
    else $error("arithmetic unit busy while idle");

  // The square root of a Q16.32 argument fits in 40 bits.
  a_sqrt_width: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bfte_pkg::S_SQRT_WAIT && div_st.done) |-> (div_res[63:40] == 24'd0))
    else $error("square root wider than 40 bits");

endmodule
